// ----- src/qtl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qtl_pkg;

    // Default length limit of a string or identifier, in characters; reaching it ends the token with an error.
    localparam int MAX_TEXT_DEF = 32;

    // Result queue depth; a scan step needs two free entries.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Token kinds.
    localparam logic [3:0] KIND_TEXT   = 4'd0;
    localparam logic [3:0] KIND_EOS    = 4'd1;
    localparam logic [3:0] KIND_STRING = 4'd2;
    localparam logic [3:0] KIND_NUMBER = 4'd3;
    localparam logic [3:0] KIND_IDENT  = 4'd4;
    localparam logic [3:0] KIND_OR     = 4'd5;
    localparam logic [3:0] KIND_LPAREN = 4'd9;
    localparam logic [3:0] KIND_RPAREN = 4'd10;
    localparam logic [3:0] KIND_COLON  = 4'd11;
    localparam logic [3:0] KIND_COMMA  = 4'd12;
    localparam logic [3:0] KIND_PIPE   = 4'd13;

    // Error codes.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_STR_LONG   = 3'd1;
    localparam logic [2:0] ERR_STR_END    = 3'd2;
    localparam logic [2:0] ERR_IDENT_LONG = 3'd3;
    localparam logic [2:0] ERR_SYMBOL     = 3'd4;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    // Keywords or, and, not, search, padded with zeros to eight places.
    localparam logic [7:0] KW_CHAR [4][8] = '{
        '{8'h6F, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h6E, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6E, 8'h6F, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h65, 8'h61, 8'h72, 8'h63, 8'h68, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [4] = '{3'd2, 3'd3, 3'd3, 3'd6};

    // One result item.
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  ch;
        logic [4:0]  idx;
        logic [31:0] num;
        logic [2:0]  err;
        logic        last;
    } res_t;

    // What one scan step hands to the result queue.
    typedef struct packed {
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } push_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_FF || c == CH_VT ||
               c == CH_LF || c == CH_CR;
    endfunction

    function automatic res_t mk_token(input logic [3:0] kind, input logic [31:0] num,
                                      input logic [2:0] err);
        res_t r;
        r.kind = kind;
        r.ch   = 8'h00;
        r.idx  = 5'd0;
        r.num  = num;
        r.err  = err;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/query_token_lexer.sv -----
// query_token_lexer: streaming tokenizer for search query text.
//
// The slave side takes one query byte per beat on s_tdata; a zero byte ends
// the query, closes any open token and yields an end-of-stream token. The
// master side gives one result per beat: token kind on m_tuser, character,
// index, number and error code packed in m_tdata, and m_tlast marking the
// final result caused by one input byte (each byte causes zero to two).
//
// Flow: a byte is taken into the input register, scanned into the result
// queue by the scan step between the input register and the queue, and its
// results are then offered from the queue. Throughput is one byte per cycle
// while the queue has room for two results; bytes that cause two results
// need two output beats, so a run of them is paced by the master side at
// one result per cycle.
//
// When the receiver stalls, results wait in a four-entry queue; the scanner
// pauses once fewer than two entries are free and then holds off s_tready.
// After reset (aresetn low, synchronous) the scanner is idle, no error is
// pending and the queue is empty.
`timescale 1ns / 1ps
`default_nettype none

module query_token_lexer #(
    parameter int MAX_TEXT = qtl_pkg::MAX_TEXT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] text_char, [12:8] text_index,
                                        // [44:13] number_value, [47:45] error_code
    output logic [3:0]       m_tuser,   // [3:0] token_kind
    output logic             m_tlast    // last_of_run
);

    logic           in_valid;
    logic [7:0]     in_byte;
    logic           room;
    logic           step;
    qtl_pkg::push_t push;

    // A byte is scanned when one is held and the queue can take two results.
    assign step = in_valid && room;

    qtl_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (step),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    qtl_scan #(
        .MAX_TEXT (MAX_TEXT)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (in_byte),
        .push    (push)
    );

    qtl_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- src/qtl_in_reg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qtl_in_reg (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       take,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register frees up in the same cycle that the scanner takes its byte.
    assign s_tready = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

// ----- src/qtl_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qtl_scan #(
    parameter int MAX_TEXT = qtl_pkg::MAX_TEXT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [7:0]  in_byte,
    output qtl_pkg::push_t   push
);

    localparam int CNT_W = ($clog2(MAX_TEXT + 1) > 3) ? $clog2(MAX_TEXT + 1) : 3;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_STRING = 5'b00010,
        MODE_IDENT  = 5'b00100,
        MODE_NUMBER = 5'b01000,
        MODE_PIPE   = 5'b10000
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      acc_reg, acc_next;
    logic [3:0]       kw_reg, kw_next;
    logic             pend_reg, pend_next;

    qtl_pkg::res_t    res [2];
    logic [1:0]       n;
    logic             run_idle;

    // Drop every keyword that no longer matches once letter c sits at pos.
    function automatic logic [3:0] kw_filter(input logic [3:0] kw,
                                             input logic [CNT_W-1:0] pos,
                                             input logic [7:0] c);
        logic [3:0] keep;
        for (int k = 0; k < 4; k++) begin
            keep[k] = kw[k] && (pos < CNT_W'(qtl_pkg::KW_LEN[k])) &&
                      (qtl_pkg::KW_CHAR[k][pos[2:0]] == c);
        end
        return keep;
    endfunction

    function automatic qtl_pkg::res_t mk_text(input logic [7:0] c,
                                              input logic [CNT_W-1:0] pos);
        qtl_pkg::res_t r;
        r      = qtl_pkg::mk_token(qtl_pkg::KIND_TEXT, 32'd0, qtl_pkg::ERR_NONE);
        r.ch   = c;
        r.idx  = 5'(pos);
        return r;
    endfunction

    function automatic logic [3:0] ident_kind(input logic [3:0] kw,
                                              input logic [CNT_W-1:0] cnt);
        logic [3:0] kind;
        kind = qtl_pkg::KIND_IDENT;
        for (int k = 0; k < 4; k++) begin
            if (kw[k] && cnt == CNT_W'(qtl_pkg::KW_LEN[k])) begin
                kind = qtl_pkg::KIND_OR + 4'(k);
            end
        end
        return kind;
    endfunction

    // One full scan step: the current mode first, then the byte from idle if needed.
    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        kw_next   = kw_reg;
        pend_next = pend_reg;
        res[0]    = qtl_pkg::mk_token(qtl_pkg::KIND_TEXT, 32'd0, qtl_pkg::ERR_NONE);
        res[1]    = qtl_pkg::mk_token(qtl_pkg::KIND_TEXT, 32'd0, qtl_pkg::ERR_NONE);
        n         = 2'd0;
        run_idle  = 1'b0;

        case (mode_reg)
            MODE_STRING: begin
                if (in_byte == qtl_pkg::CH_QUOTE) begin
                    res[0] = qtl_pkg::mk_token(qtl_pkg::KIND_STRING, 32'd0,
                                               qtl_pkg::ERR_NONE);
                    n         = 2'd1;
                    pend_next = 1'b0;
                    mode_next = MODE_IDLE;
                end else if (in_byte == qtl_pkg::CH_NUL || in_byte == qtl_pkg::CH_LF ||
                             in_byte == qtl_pkg::CH_CR) begin
                    res[0] = qtl_pkg::mk_token(qtl_pkg::KIND_STRING, 32'd0,
                                               qtl_pkg::ERR_STR_END);
                    n         = 2'd1;
                    pend_next = 1'b0;
                    mode_next = MODE_IDLE;
                    run_idle  = (in_byte == qtl_pkg::CH_NUL);
                end else begin
                    res[0]   = mk_text(in_byte, cnt_reg);
                    n        = 2'd1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= CNT_W'(MAX_TEXT)) begin
                        res[1] = qtl_pkg::mk_token(qtl_pkg::KIND_STRING, 32'd0,
                                                   qtl_pkg::ERR_STR_LONG);
                        n         = 2'd2;
                        pend_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_IDENT: begin
                if (qtl_pkg::is_letter(in_byte)) begin
                    kw_next  = kw_filter(kw_reg, cnt_reg, in_byte);
                    res[0]   = mk_text(in_byte, cnt_reg);
                    n        = 2'd1;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_next >= CNT_W'(MAX_TEXT)) begin
                        res[1] = qtl_pkg::mk_token(qtl_pkg::KIND_IDENT, 32'd0,
                                                   qtl_pkg::ERR_IDENT_LONG);
                        n         = 2'd2;
                        pend_next = 1'b0;
                        mode_next = MODE_IDLE;
                    end
                end else begin
                    res[0] = qtl_pkg::mk_token(ident_kind(kw_reg, cnt_reg), 32'd0,
                                               pend_reg ? qtl_pkg::ERR_SYMBOL
                                                        : qtl_pkg::ERR_NONE);
                    n         = 2'd1;
                    pend_next = 1'b0;
                    run_idle  = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (qtl_pkg::is_digit(in_byte)) begin
                    acc_next = (acc_reg << 3) + (acc_reg << 1) +
                               32'(in_byte - qtl_pkg::CH_ZERO);
                end else begin
                    res[0] = qtl_pkg::mk_token(qtl_pkg::KIND_NUMBER, acc_reg,
                                               pend_reg ? qtl_pkg::ERR_SYMBOL
                                                        : qtl_pkg::ERR_NONE);
                    n         = 2'd1;
                    pend_next = 1'b0;
                    run_idle  = 1'b1;
                end
            end
            MODE_PIPE: begin
                mode_next = MODE_IDLE;
                if (in_byte == qtl_pkg::CH_GT) begin
                    res[0] = qtl_pkg::mk_token(qtl_pkg::KIND_PIPE, 32'd0,
                                               pend_reg ? qtl_pkg::ERR_SYMBOL
                                                        : qtl_pkg::ERR_NONE);
                    n         = 2'd1;
                    pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                    run_idle  = 1'b1;
                end
            end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        // Scan the byte as if no token were open; this emits at most one result.
        if (run_idle) begin
            mode_next = MODE_IDLE;
            if (in_byte == qtl_pkg::CH_NUL) begin
                res[n[0]] = qtl_pkg::mk_token(qtl_pkg::KIND_EOS, 32'd0,
                                              pend_next ? qtl_pkg::ERR_SYMBOL
                                                        : qtl_pkg::ERR_NONE);
                n         = n + 2'd1;
                pend_next = 1'b0;
            end else if (qtl_pkg::is_space(in_byte)) begin
                mode_next = MODE_IDLE;
            end else if (in_byte == qtl_pkg::CH_QUOTE) begin
                mode_next = MODE_STRING;
                cnt_next  = '0;
            end else if (qtl_pkg::is_digit(in_byte)) begin
                mode_next = MODE_NUMBER;
                acc_next  = 32'(in_byte - qtl_pkg::CH_ZERO);
            end else if (qtl_pkg::is_letter(in_byte)) begin
                mode_next = MODE_IDENT;
                cnt_next  = CNT_W'(1);
                kw_next   = kw_filter(4'hF, '0, in_byte);
                res[n[0]] = mk_text(in_byte, '0);
                n         = n + 2'd1;
            end else if (in_byte == qtl_pkg::CH_LPAREN || in_byte == qtl_pkg::CH_RPAREN ||
                         in_byte == qtl_pkg::CH_COLON || in_byte == qtl_pkg::CH_COMMA) begin
                res[n[0]] = qtl_pkg::mk_token(
                    (in_byte == qtl_pkg::CH_LPAREN) ? qtl_pkg::KIND_LPAREN :
                    (in_byte == qtl_pkg::CH_RPAREN) ? qtl_pkg::KIND_RPAREN :
                    (in_byte == qtl_pkg::CH_COLON)  ? qtl_pkg::KIND_COLON  :
                                                      qtl_pkg::KIND_COMMA,
                    32'd0, pend_next ? qtl_pkg::ERR_SYMBOL : qtl_pkg::ERR_NONE);
                n         = n + 2'd1;
                pend_next = 1'b0;
            end else if (in_byte == qtl_pkg::CH_BAR) begin
                mode_next = MODE_PIPE;
            end else begin
                pend_next = 1'b1;
            end
        end

        // The final result of the step closes the run.
        if (n == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    assign push.cnt = step ? n : 2'd0;
    assign push.r0  = res[0];
    assign push.r1  = res[1];

    // Scanner state moves only when a byte is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            cnt_reg  <= '0;
            acc_reg  <= '0;
            kw_reg   <= '0;
            pend_reg <= 1'b0;
        end else if (step) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            kw_reg   <= kw_next;
            pend_reg <= pend_next;
        end
    end

    // An open string or identifier never holds a full count of characters.
    a_text_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_STRING || mode_reg == MODE_IDENT) |->
            cnt_reg < CNT_W'(MAX_TEXT))
        else $error("text count reached the limit inside an open token");

    // An identifier in progress always holds at least one letter.
    a_ident_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_IDENT |-> cnt_reg != '0)
        else $error("identifier mode with no letters");

endmodule

`default_nettype wire

// ----- src/qtl_res_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module qtl_res_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire qtl_pkg::push_t  push,
    output logic                 room,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [47:0]          m_tdata,  // [7:0] text_char, [12:8] text_index,
                                           // [44:13] number_value, [47:45] error_code
    output logic [3:0]           m_tuser,  // [3:0] token_kind
    output logic                 m_tlast   // last_of_run
);

    localparam int PW = qtl_pkg::FIFO_PTR_W;
    localparam int CW = qtl_pkg::FIFO_CNT_W;

    qtl_pkg::res_t mem_reg [qtl_pkg::FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    qtl_pkg::res_t head;

    // A scan step may add two results, so it waits for two free entries.
    assign room     = count_reg <= CW'(qtl_pkg::FIFO_DEPTH - 2);
    assign m_tvalid = count_reg != '0;
    assign pop      = m_tvalid && m_tready;

    assign head    = mem_reg[rd_ptr_reg];
    assign m_tdata = {head.err, head.num, head.idx, head.ch};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage: first result at the write pointer, second one after it.
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[PW'(wr_ptr_reg + 1'b1)] <= push.r1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> room)
        else $error("results pushed without two free entries");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(qtl_pkg::FIFO_DEPTH))
        else $error("result queue count beyond depth");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.cnt == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("result queue count did not drop after a beat left");

endmodule

`default_nettype wire

// ----- test/query_token_checker.sv -----
`timescale 1ns / 1ps

module query_token_checker
    import qtl_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,   // [7:0] text_char, [12:8] text_index,
                                        // [44:13] number_value, [47:45] error_code
    input  wire logic [3:0]  m_tuser,   // [3:0] token_kind
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               awaiting
);

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_STRING,
        SCAN_IDENT,
        SCAN_NUMBER,
        SCAN_AFTER_BAR
    } scan_state_e;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam int         REPORT_MAX = 10;

    // Scanner state as the predictor sees it.
    scan_state_e scan_state;
    int          text_len;
    logic [31:0] number_acc;
    logic [3:0]  kw_alive;
    logic [2:0]  error_held;

    // Results of the byte being scanned, and tokens still owed by the block.
    res_t        step_out[$];
    res_t        token_q[$];
    int          errs;

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    task automatic push_result(input logic [3:0] kind, input logic [7:0] ch,
                               input logic [4:0] idx, input logic [31:0] num,
                               input logic [2:0] err);
        res_t r;
        r.kind = kind;
        r.ch   = ch;
        r.idx  = idx;
        r.num  = num;
        r.err  = err;
        r.last = 1'b0;
        step_out.push_back(r);
    endtask

    // A token takes over any held error and clears it.
    task automatic push_token(input logic [3:0] kind, input logic [31:0] num);
        push_result(kind, 8'h00, 5'd0, num, error_held);
        error_held = ERR_NONE;
    endtask

    // A string token carries its own code, never the held one.
    task automatic close_string(input logic [2:0] err);
        push_result(KIND_STRING, 8'h00, 5'd0, '0, err);
        error_held = ERR_NONE;
        scan_state = SCAN_IDLE;
    endtask

    // One identifier letter: narrow the keyword set, emit the letter, and
    // cut the identifier short once it reaches the length limit.
    task automatic take_letter(input logic [7:0] c);
        for (int k = 0; k < 4; k++) begin
            if (kw_alive[k] && (text_len >= KW_LEN[k] || KW_CHAR[k][text_len] != c))
                kw_alive[k] = 1'b0;
        end
        push_result(KIND_TEXT, c, text_len[4:0], '0, ERR_NONE);
        text_len++;
        if (text_len >= MAX_TEXT) begin
            push_result(KIND_IDENT, 8'h00, 5'd0, '0, ERR_IDENT_LONG);
            error_held = ERR_NONE;
            scan_state = SCAN_IDLE;
        end
    endtask

    task automatic scan_idle(input logic [7:0] c);
        scan_state = SCAN_IDLE;
        case (c)
            CH_NUL:    push_token(KIND_EOS, '0);
            CH_SPACE, CH_TAB, CH_FF, CH_VT, CH_LF, CH_CR: ;
            CH_QUOTE: begin
                scan_state = SCAN_STRING;
                text_len   = 0;
            end
            CH_LPAREN: push_token(KIND_LPAREN, '0);
            CH_RPAREN: push_token(KIND_RPAREN, '0);
            CH_COLON:  push_token(KIND_COLON, '0);
            CH_COMMA:  push_token(KIND_COMMA, '0);
            CH_BAR:    scan_state = SCAN_AFTER_BAR;
            default: begin
                if (digit_byte(c)) begin
                    scan_state = SCAN_NUMBER;
                    number_acc = c - CH_ZERO;
                end else if (letter_byte(c)) begin
                    scan_state = SCAN_IDENT;
                    text_len   = 0;
                    kw_alive   = 4'hF;
                    take_letter(c);
                end else begin
                    error_held = ERR_SYMBOL;
                end
            end
        endcase
    endtask

    // Work out every result one input byte causes and queue them in order.
    task automatic scan_byte(input logic [7:0] c);
        logic [3:0] word_kind;
        step_out.delete();
        case (scan_state)
            SCAN_STRING: begin
                if (c == CH_QUOTE) begin
                    close_string(ERR_NONE);
                end else if (c == CH_NUL || c == CH_LF || c == CH_CR) begin
                    close_string(ERR_STR_END);
                    if (c == CH_NUL)
                        scan_idle(c);
                end else begin
                    push_result(KIND_TEXT, c, text_len[4:0], '0, ERR_NONE);
                    text_len++;
                    if (text_len >= MAX_TEXT)
                        close_string(ERR_STR_LONG);
                end
            end
            SCAN_IDENT: begin
                if (letter_byte(c)) begin
                    take_letter(c);
                end else begin
                    word_kind = KIND_IDENT;
                    for (int k = 0; k < 4; k++) begin
                        if (kw_alive[k] && text_len == KW_LEN[k])
                            word_kind = KIND_OR + 4'(k);
                    end
                    push_token(word_kind, '0);
                    scan_idle(c);
                end
            end
            SCAN_NUMBER: begin
                if (digit_byte(c)) begin
                    number_acc = number_acc * 32'd10 + (c - CH_ZERO);
                end else begin
                    push_token(KIND_NUMBER, number_acc);
                    scan_idle(c);
                end
            end
            SCAN_AFTER_BAR: begin
                scan_state = SCAN_IDLE;
                if (c == CH_GT) begin
                    push_token(KIND_PIPE, '0);
                end else begin
                    error_held = ERR_SYMBOL;
                    scan_idle(c);
                end
            end
            default: scan_idle(c);
        endcase
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i])
            token_q.push_back(step_out[i]);
    endtask

    // Predict on each accepted input beat, compare on each accepted output beat.
    always @(posedge aclk) begin
        res_t seen;
        res_t want;
        if (!aresetn) begin
            scan_state = SCAN_IDLE;
            text_len   = 0;
            number_acc = '0;
            kw_alive   = '0;
            error_held = ERR_NONE;
            token_q.delete();
            errs       = 0;
        end else begin
            if (s_tvalid && s_tready)
                scan_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                seen.kind = m_tuser;
                seen.ch   = m_tdata[7:0];
                seen.idx  = m_tdata[12:8];
                seen.num  = m_tdata[44:13];
                seen.err  = m_tdata[47:45];
                seen.last = m_tlast;
                if (token_q.size() == 0) begin
                    errs++;
                    if (errs <= REPORT_MAX)
                        $display("%0t: result beat with nothing expected: kind %0d", $realtime,
                                 seen.kind);
                end else begin
                    want = token_q.pop_front();
                    if (seen.kind != want.kind || seen.ch != want.ch || seen.idx != want.idx ||
                        seen.num != want.num || seen.err != want.err ||
                        seen.last != want.last) begin
                        errs++;
                        if (errs <= REPORT_MAX) begin
                            $display("%0t: expected kind %0d char %02h index %0d number %0d",
                                     $realtime, want.kind, want.ch, want.idx,
                                     $signed(want.num));
                            $display("    error %0d last %0b; got kind %0d char %02h index %0d",
                                     want.err, want.last, seen.kind, seen.ch, seen.idx);
                            $display("    number %0d error %0d last %0b",
                                     $signed(seen.num), seen.err, seen.last);
                        end
                    end
                end
            end
        end
        fail_count <= errs;
        awaiting   <= token_q.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import qtl_pkg::*;

    typedef enum int {
        RX_OPEN,
        RX_SPARSE,
        RX_PERIODIC,
        RX_COIN
    } rx_mode_e;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam int         BYTE_GOAL = 440;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] text_char, [12:8] text_index,
                                    // [44:13] number_value, [47:45] error_code
    logic [3:0]  m_tuser;           // [3:0] token_kind
    logic        m_tlast;
    int          fail_count;
    int          awaiting;

    int          burst_left = 0;
    int          bytes_sent = 0;
    rx_mode_e    rx_mode = RX_OPEN;
    int          rx_hold = 0;

    string       keywords[4] = '{"or", "and", "not", "search"};
    logic [7:0]  blanks[6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

    always #6 aclk = ~aclk;

    query_token_lexer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    query_token_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .awaiting   (awaiting)
    );

    // Receiver: switch between open, sparse, periodic and coin-flip stalling.
    always @(posedge aclk) begin
        if (rx_hold == 0) begin
            rx_mode <= rx_mode_e'($urandom_range(0, 3));
            rx_hold <= $urandom_range(20, 120);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_SPARSE:   m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_tready <= (rx_hold % 7) < 2;
            default:     m_tready <= ($urandom_range(0, 1) == 1);
        endcase
    end

    // Sender: bursts of back-to-back beats with random gaps in between.
    task automatic put_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++)
            put_byte(t[i]);
    endtask

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? UPPER_A : LOWER_A) + 8'($urandom_range(0, 25));
    endfunction

    // One random token, mostly well formed, sometimes broken or noise.
    task automatic send_token();
        int    len;
        string word;
        logic [7:0] c;
        case ($urandom_range(0, 11))
            0, 1, 2: begin
                if ($urandom_range(0, 2) != 0) begin
                    // keyword, sometimes clipped or extended so it misses
                    word = keywords[$urandom_range(0, 3)];
                    case ($urandom_range(0, 5))
                        0: word = word.substr(0, word.len() - 2);
                        1: word = {word, "s"};
                        2: word = word.toupper();
                        default: ;
                    endcase
                    put_text(word);
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34)
                                                      : $urandom_range(1, 8);
                    repeat (len) put_byte(any_letter());
                end
            end
            3, 4: begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 12)
                                                  : $urandom_range(1, 4);
                repeat (len) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            5, 6: begin
                put_byte(CH_QUOTE);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 34)
                                                  : $urandom_range(0, 6);
                repeat (len) begin
                    do c = 8'($urandom_range(1, 255));
                    while (c == CH_QUOTE || c == CH_LF || c == CH_CR);
                    put_byte(c);
                end
                case ($urandom_range(0, 7))
                    0: put_byte(CH_LF);
                    1: put_byte(CH_CR);
                    2: put_byte(CH_NUL);
                    default: put_byte(CH_QUOTE);
                endcase
            end
            7, 8: begin
                case ($urandom_range(0, 4))
                    0: put_byte(CH_LPAREN);
                    1: put_byte(CH_RPAREN);
                    2: put_byte(CH_COLON);
                    3: put_byte(CH_COMMA);
                    default: begin
                        put_byte(CH_BAR);
                        put_byte(CH_GT);
                    end
                endcase
            end
            9: begin
                put_byte(CH_BAR);
                put_byte(8'($urandom_range(0, 255)));
            end
            10: put_byte(8'($urandom_range(0, 255)));
            default: put_byte(CH_NUL);
        endcase
        if ($urandom_range(0, 1) == 1)
            put_byte(blanks[$urandom_range(0, 5)]);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Keywords or, search and not, symbols, broken string, pipe, lone bar, high byte, end.
        put_text("(or,search:\"A\n|>|q");
        put_byte(8'hFF);
        put_text("not 7)");
        put_byte(CH_NUL);

        while (bytes_sent < BYTE_GOAL)
            send_token();
        put_byte(CH_NUL);
        s_tvalid <= 1'b0;

        // Let the last tokens drain, then allow for anything stray.
        @(posedge aclk);
        while (awaiting != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && awaiting == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- query_token_lexer.f -----
src/qtl_pkg.sv
src/qtl_in_reg.sv
src/qtl_scan.sv
src/qtl_res_fifo.sv
src/query_token_lexer.sv
test/query_token_checker.sv
test/testbench.sv
